// ===== src/fnm_pkg.sv =====
`timescale 1ns / 1ps
package fnm_pkg;
    localparam int MAX_POINTS = 256;
    localparam int MAX_PAIRS = 64;
    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = PW + 1;
    localparam int FW = 48;
    localparam int DW = 34;
    localparam int NW = 7;

    localparam logic [1:0] REQ_SRC = 2'd0;
    localparam logic [1:0] REQ_TGT = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic CFG_PAIRS = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic [NW-1:0] PAIRS_RESET = NW'(64);
    localparam logic [DW-1:0] LIMIT_RESET = DW'(64'd16777216);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MRD,
        ST_MWAIT,
        ST_MACC,
        ST_MWR,
        ST_SRD,
        ST_SWAIT,
        ST_SCMP,
        ST_EMIT,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic load_src;
        logic load_tgt;
        logic m_init_src;
        logic m_init_tgt;
        logic m_next_tgt;
        logic m_acc;
        logic m_write;
        logic m_next_src;
        logic s_init_k;
        logic s_init_scan;
        logic s_next_scan;
        logic s_cmp;
        logic emit;
        logic next_k;
    } t_cmd;

    typedef struct packed {
        logic tgt_done;
        logic tgt_drained;
        logic src_done;
        logic scan_done;
        logic k_done;
        logic no_src;
    } t_status;
endpackage

// ===== src/fnm_if.sv =====
`timescale 1ns / 1ps
interface fnm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic signed [15:0] feat_x;
    logic signed [15:0] feat_y;
    logic signed [15:0] feat_z;
    modport source (output valid, req_type, feat_x, feat_y, feat_z, input ready);
    modport sink (input valid, req_type, feat_x, feat_y, feat_z, output ready);
endinterface

interface fnm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  source_index;
    logic [7:0]  target_index;
    logic        match_found;
    logic [33:0] distance_sq;
    logic        last_pair;
    modport source (output valid, source_index, target_index, match_found,
        distance_sq, last_pair, input ready);
    modport sink (input valid, source_index, target_index, match_found,
        distance_sq, last_pair, output ready);
endinterface

interface fnm_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [33:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/fnm_ram.sv =====
`timescale 1ns / 1ps
module fnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/fnm_ctrl.sv =====
`timescale 1ns / 1ps
module fnm_ctrl import fnm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic [1:0] i_req_type,
    output logic      o_in_ready,
    input  logic      i_out_busy,
    input  t_status   i_status,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_src = (i_req_type == REQ_SRC);
                    o_cmd.load_tgt = (i_req_type == REQ_TGT);
                    if (i_req_type == REQ_START) begin
                        o_cmd.m_init_src = 1'b1;
                        n_state = ST_MRD;
                    end
                end
            end
            ST_MRD: begin
                // begin one source: its features read out, target pointer zeroed
                if (i_status.src_done) begin
                    o_cmd.s_init_k = 1'b1;
                    n_state = i_status.no_src ? ST_IDLE : ST_SRD;
                end else begin
                    o_cmd.m_init_tgt = 1'b1;
                    n_state = ST_MWAIT;
                end
            end
            ST_MWAIT: begin
                n_state = i_status.tgt_done ? ST_MWR : ST_MACC;
                o_cmd.m_next_tgt = !i_status.tgt_done;
            end
            ST_MACC: begin
                // hold until the last target has gone through the compare
                o_cmd.m_acc = 1'b1;
                if (i_status.tgt_drained) begin
                    n_state = ST_MWR;
                end else begin
                    o_cmd.m_next_tgt = !i_status.tgt_done;
                end
            end
            ST_MWR: begin
                o_cmd.m_write = 1'b1;
                o_cmd.m_next_src = 1'b1;
                n_state = ST_MRD;
            end
            ST_SRD: begin
                o_cmd.s_init_scan = 1'b1;
                n_state = ST_SWAIT;
            end
            ST_SWAIT: begin
                o_cmd.s_next_scan = 1'b1;
                n_state = ST_SCMP;
            end
            ST_SCMP: begin
                if (i_status.scan_done) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.s_cmp = 1'b1;
                    o_cmd.s_next_scan = 1'b1;
                end
            end
            ST_EMIT: begin
                if (!i_out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.next_k = 1'b1;
                    n_state = i_status.k_done ? ST_HOLD : ST_SRD;
                end
            end
            ST_HOLD: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== src/fnm_dp.sv =====
`timescale 1ns / 1ps
module fnm_dp import fnm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    input  logic [FW-1:0] i_feat,
    input  logic [NW-1:0] i_pairs,
    input  logic [DW-1:0] i_limit,
    output logic [7:0]    o_src_idx,
    output logic [7:0]    o_tgt_idx,
    output logic          o_found,
    output logic [DW-1:0] o_dist,
    output logic          o_last
);
    localparam int BW = DW + PW + 2; // distance, target, found, emitted

    logic [CW-1:0] r_src_cnt, r_tgt_cnt;
    logic [CW-1:0] r_s, r_t, r_t_d;
    logic [CW-1:0] r_scan, r_scan_d;
    logic [NW-1:0] r_k, r_n;
    logic [DW-1:0] r_best;
    logic [PW-1:0] r_bt;
    logic          r_bf;
    logic          r_have;
    logic [DW-1:0] r_pd;
    logic [PW-1:0] r_pick, r_ptgt;
    logic          r_pf;
    logic [2*17-1:0] r_sq_x, r_sq_y, r_sq_z;
    logic          r_sq_v;

    logic [FW-1:0] src_rd, tgt_rd, r_src_f;
    logic [BW-1:0] best_rd, best_wd;
    logic [PW-1:0] src_wa, tgt_wa, src_ra, best_ra, best_wa;
    logic          src_we, tgt_we, best_we;
    logic signed [16:0] dx, dy, dz;
    logic [16:0] ax, ay, az;
    logic [DW-1:0] dsum;
    logic [CW-1:0] n_full;
    logic [NW-1:0] npairs;

    assign src_we = i_cmd.load_src && (r_src_cnt < CW'(MAX_POINTS));
    assign tgt_we = i_cmd.load_tgt && (r_tgt_cnt < CW'(MAX_POINTS));
    assign src_wa = r_src_cnt[PW-1:0];
    assign tgt_wa = r_tgt_cnt[PW-1:0];
    assign src_ra = r_s[PW-1:0];
    assign best_ra = r_scan[PW-1:0];
    // match pass writes each source with the emitted flag clear; emit sets it
    assign best_we = i_cmd.m_write || i_cmd.emit;
    assign best_wa = i_cmd.emit ? r_pick : r_s[PW-1:0];
    assign best_wd = i_cmd.emit ? {r_pd, r_ptgt, r_pf, 1'b1} : {r_best, r_bt, r_bf, 1'b0};

    fnm_ram #(.WIDTH(FW), .DEPTH(MAX_POINTS)) u_src (
        .i_clk(i_clk), .i_we(src_we), .i_waddr(src_wa), .i_wdata(i_feat),
        .i_raddr(src_ra), .o_rdata(src_rd));
    fnm_ram #(.WIDTH(FW), .DEPTH(MAX_POINTS)) u_tgt (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_wa), .i_wdata(i_feat),
        .i_raddr(r_t[PW-1:0]), .o_rdata(tgt_rd));
    fnm_ram #(.WIDTH(BW), .DEPTH(MAX_POINTS)) u_best (
        .i_clk(i_clk), .i_we(best_we), .i_waddr(best_wa),
        .i_wdata(best_wd), .i_raddr(best_ra), .o_rdata(best_rd));

    // component differences from registered source and target reads
    always_comb begin
        dx = 17'(signed'(r_src_f[47:32])) - 17'(signed'(tgt_rd[47:32]));
        dy = 17'(signed'(r_src_f[31:16])) - 17'(signed'(tgt_rd[31:16]));
        dz = 17'(signed'(r_src_f[15:0])) - 17'(signed'(tgt_rd[15:0]));
        ax = dx[16] ? 17'(-dx) : 17'(dx);
        ay = dy[16] ? 17'(-dy) : 17'(dy);
        az = dz[16] ? 17'(-dz) : 17'(dz);
        dsum = DW'(r_sq_x) + DW'(r_sq_y) + DW'(r_sq_z);
    end

    always_comb begin
        n_full = (i_pairs > NW'(MAX_PAIRS)) ? CW'(MAX_PAIRS) : CW'(i_pairs);
        if (n_full > r_src_cnt) n_full = r_src_cnt;
        npairs = NW'(n_full);
    end

    assign o_status.tgt_done = (r_t == r_tgt_cnt);
    assign o_status.tgt_drained = (r_t_d == r_tgt_cnt);
    assign o_status.src_done = (r_s == r_src_cnt);
    assign o_status.scan_done = (r_scan_d == r_src_cnt);
    assign o_status.k_done = (r_k + NW'(1) == r_n);
    assign o_status.no_src = (npairs == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cnt <= '0;
            r_tgt_cnt <= '0;
            r_sq_v <= 1'b0;
        end else begin
            if (src_we) r_src_cnt <= r_src_cnt + CW'(1);
            if (tgt_we) r_tgt_cnt <= r_tgt_cnt + CW'(1);
            r_sq_v <= i_cmd.m_acc && (r_t_d != r_tgt_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.m_init_src) r_s <= '0;
        if (i_cmd.m_next_src) r_s <= r_s + CW'(1);
        if (i_cmd.m_init_tgt) begin
            r_t <= '0;
            r_best <= i_limit;
            r_bt <= '0;
            r_bf <= 1'b0;
        end
        if (i_cmd.m_next_tgt) r_t <= r_t + CW'(1);
        r_t_d <= r_t;
        // source read is registered behind the pointer; take it before target 0
        if (i_cmd.m_next_tgt && r_t == '0) r_src_f <= src_rd;
        r_sq_x <= 34'(ax * ax);
        r_sq_y <= 34'(ay * ay);
        r_sq_z <= 34'(az * az);
        if (r_sq_v && dsum < r_best) begin
            r_best <= dsum;
            r_bt <= PW'(r_t_d - CW'(1));
            r_bf <= 1'b1;
        end
        if (i_cmd.s_init_k) begin
            r_k <= '0;
            r_n <= npairs;
        end
        if (i_cmd.next_k) r_k <= r_k + NW'(1);
        if (i_cmd.s_init_scan) begin
            r_scan <= '0;
            r_have <= 1'b0;
        end
        if (i_cmd.s_next_scan) r_scan <= r_scan + CW'(1);
        r_scan_d <= r_scan;
        if (i_cmd.s_cmp && !best_rd[0]) begin
            if (!r_have || best_rd[BW-1 -: DW] < r_pd) begin
                r_have <= 1'b1;
                r_pd <= best_rd[BW-1 -: DW];
                r_ptgt <= best_rd[PW+1:2];
                r_pf <= best_rd[1];
                r_pick <= r_scan_d[PW-1:0];
            end
        end
        if (i_cmd.emit) begin
            o_src_idx <= 8'(r_pick);
            o_tgt_idx <= r_pf ? 8'(r_ptgt) : 8'd0;
            o_found <= r_pf;
            o_dist <= r_pd;
            o_last <= o_status.k_done;
        end
    end
endmodule

// ===== src/feature_nearest_match_topk.sv =====
`timescale 1ns / 1ps
// Nearest-target matching over loaded feature vectors, best pairs out.
// Input channel: req_type 0 loads a source feature, 1 a target feature,
// 2 starts a run; code 3 is dropped. Loads give no transfer out. A start
// walks every source against every target through one squared-distance
// unit (one target per cycle), then emits min(pairs_wanted, 64, source
// count) pairs, each found by a scan over all source results held in the
// result memory. The last pair carries last_pair. Input ready is low
// during the run. The output register holds a pair until the receiver
// takes it; a stalled receiver holds the selection sequencer. Reset empties
// both stores and sets pairs_wanted to 64 and the limit to 1.0; no clearing
// pass is needed.
// Config writes are taken at any time and must come only while idle.
module feature_nearest_match_topk import fnm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    fnm_in_if.sink    in_ch,
    fnm_out_if.source out_ch,
    fnm_cfg_if.sink   cfg_ch
);
    t_cmd    cmd;
    t_status status;
    logic    r_out_valid;
    logic [NW-1:0] r_pairs;
    logic [DW-1:0] r_limit;
    logic [7:0]  src_idx, tgt_idx;
    logic        found, last;
    logic [DW-1:0] out_dist;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs <= PAIRS_RESET;
            r_limit <= LIMIT_RESET;
        end else if (cfg_ch.valid) begin
            if (cfg_ch.index == CFG_PAIRS) r_pairs <= cfg_ch.data[NW-1:0];
            if (cfg_ch.index == CFG_LIMIT) r_limit <= cfg_ch.data;
        end
    end

    // output register: set on emit, cleared on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    fnm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid),
        .i_req_type(in_ch.req_type), .o_in_ready(in_ch.ready),
        .i_out_busy(r_out_valid && !out_ch.ready), .i_status(status),
        .o_cmd(cmd));

    fnm_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_feat({in_ch.feat_x, in_ch.feat_y, in_ch.feat_z}),
        .i_pairs(r_pairs), .i_limit(r_limit),
        .o_src_idx(src_idx), .o_tgt_idx(tgt_idx), .o_found(found),
        .o_dist(out_dist), .o_last(last));

    assign out_ch.valid = r_out_valid;
    assign out_ch.source_index = src_idx;
    assign out_ch.target_index = tgt_idx;
    assign out_ch.match_found = found;
    assign out_ch.distance_sq = out_dist;
    assign out_ch.last_pair = last;

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.match_found |-> out_ch.distance_sq < r_limit)
        else $error("match above limit");
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.match_found |-> out_ch.target_index == 8'd0)
        else $error("unmatched with index");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !in_ch.ready || out_ch.last_pair)
        else $error("input taken mid-run");
endmodule

// ===== tb/sv/feature_nearest_match_topk_test.sv =====
`timescale 1ns / 1ps
module feature_nearest_match_topk_test;
    import fnm_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [DW-1:0] LIMIT_TOP = DW'(64'd12884508675);

    typedef struct {
        logic [7:0]    src_idx;
        logic [7:0]    tgt_idx;
        logic          found;
        logic [DW-1:0] dist_sq;
        logic          last;
    } t_match_pair;

    logic i_clk;
    logic i_rst_n;

    fnm_in_if  in_ch ();
    fnm_out_if out_ch ();
    fnm_cfg_if cfg_ch ();

    feature_nearest_match_topk u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    // Predictor state: the stores, the counts and the two registers.
    logic signed [15:0] src_feat [MAX_POINTS][3];
    logic signed [15:0] tgt_feat [MAX_POINTS][3];
    int unsigned        src_count;
    int unsigned        tgt_count;
    logic [NW-1:0]      pairs_wanted;
    logic [DW-1:0]      match_limit;
    int unsigned        settle_cycles;

    t_match_pair pending_pairs[$];
    int unsigned mismatches;
    int unsigned out_hold_cycles;
    bit          sender_no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    // Squared L2 distance between a source and a target, Q.24.
    function automatic logic [DW-1:0] feat_dist_sq(int unsigned s, int unsigned t);
        longint acc;
        longint diff;
        acc = 0;
        for (int c = 0; c < 3; c++) begin
            diff = longint'(src_feat[s][c]) - longint'(tgt_feat[t][c]);
            acc += diff * diff;
        end
        return DW'(acc);
    endfunction

    // Match every source, then queue the best pairs in ascending distance.
    task automatic predict_matches();
        logic [DW-1:0] best_d [MAX_POINTS];
        int unsigned   best_t [MAX_POINTS];
        bit            best_ok [MAX_POINTS];
        bit            taken [MAX_POINTS];
        int unsigned   n_pairs;
        int unsigned   pick;
        bit            have;
        logic [DW-1:0] d;
        t_match_pair   p;
        for (int unsigned s = 0; s < src_count; s++) begin
            best_d[s] = match_limit;
            best_t[s] = 0;
            best_ok[s] = 1'b0;
            taken[s] = 1'b0;
            for (int unsigned t = 0; t < tgt_count; t++) begin
                d = feat_dist_sq(s, t);
                if (d < best_d[s]) begin
                    best_d[s] = d;
                    best_t[s] = t;
                    best_ok[s] = 1'b1;
                end
            end
        end
        n_pairs = pairs_wanted;
        if (n_pairs > MAX_PAIRS) n_pairs = MAX_PAIRS;
        if (n_pairs > src_count) n_pairs = src_count;
        // A run with no pairs still walks the stores; remember how long.
        settle_cycles = (n_pairs == 0) ? src_count * (tgt_count + 6) + 100 : 20;
        for (int unsigned k = 0; k < n_pairs; k++) begin
            pick = 0;
            have = 1'b0;
            for (int unsigned s = 0; s < src_count; s++) begin
                if (!taken[s] && (!have || best_d[s] < best_d[pick])) begin
                    pick = s;
                    have = 1'b1;
                end
            end
            taken[pick] = 1'b1;
            p.src_idx = 8'(pick);
            p.tgt_idx = best_ok[pick] ? 8'(best_t[pick]) : 8'd0;
            p.found = best_ok[pick];
            p.dist_sq = best_d[pick];
            p.last = (k + 1 == n_pairs);
            pending_pairs.push_back(p);
        end
    endtask

    // Drive one request and hold it until the block takes it.
    task automatic send_req(logic [1:0] req, logic signed [15:0] x,
            logic signed [15:0] y, logic signed [15:0] z);
        int unsigned gap;
        gap = 0;
        if (!sender_no_gaps) begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = $urandom_range(1, 3);
                3: gap = $urandom_range(10, 40);
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.req_type <= req;
        in_ch.feat_x <= x;
        in_ch.feat_y <= y;
        in_ch.feat_z <= z;
        do @(posedge i_clk); while (!in_ch.ready);
        case (req)
            REQ_SRC: begin
                if (src_count < MAX_POINTS) begin
                    src_feat[src_count] = '{x, y, z};
                    src_count++;
                end
            end
            REQ_TGT: begin
                if (tgt_count < MAX_POINTS) begin
                    tgt_feat[tgt_count] = '{x, y, z};
                    tgt_count++;
                end
            end
            REQ_START: predict_matches();
            default: ;
        endcase
    endtask

    task automatic release_input();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // Hold off until every pair is out and the block has gone back to idle.
    task automatic wait_idle();
        release_input();
        wait (pending_pairs.size() == 0);
        repeat (settle_cycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [DW-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CFG_PAIRS) pairs_wanted = value[NW-1:0];
        else match_limit = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly clustered features so that matches fall under the limit;
    // now and then a full-range value to exercise every bit.
    function automatic logic signed [15:0] rand_comp();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 6143)) - 3072);
    endfunction

    task automatic load_random(int unsigned n_src, int unsigned n_tgt);
        int unsigned ns;
        int unsigned nt;
        ns = 0;
        nt = 0;
        while (ns < n_src || nt < n_tgt) begin
            if ($urandom_range(0, 19) == 0) begin
                send_req(REQ_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (nt >= n_tgt || (ns < n_src && $urandom_range(0, 1))) begin
                send_req(REQ_SRC, rand_comp(), rand_comp(), rand_comp());
                ns++;
            end else begin
                send_req(REQ_TGT, rand_comp(), rand_comp(), rand_comp());
                nt++;
            end
        end
    endtask

    task automatic start_run();
        send_req(REQ_START, 16'($urandom), 16'($urandom), 16'($urandom));
        wait_idle();
    endtask

    // Empty source store, then sources with no targets: all unmatched.
    task automatic test_empty_stores();
        start_run();
        send_req(REQ_SRC, 16'sd0, 16'sd100, -16'sd100);
        send_req(REQ_SRC, 16'sd4096, 16'sd0, 16'sd0);
        send_req(REQ_SRC, 16'sd0, 16'sd0, 16'sd0);
        start_run();
    endtask

    // Field extremes, the unused code, ties and the limit boundaries.
    task automatic test_extremes();
        send_req(REQ_SRC, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_req(REQ_SRC, -16'sh8000, -16'sh8000, -16'sh8000);
        send_req(REQ_UNUSED, 16'sh7fff, -16'sh8000, 16'sh5555);
        send_req(REQ_TGT, -16'sh8000, -16'sh8000, -16'sh8000);
        send_req(REQ_TGT, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_req(REQ_TGT, 16'sd0, 16'sd0, 16'sd0);
        send_req(REQ_TGT, 16'sd0, 16'sd0, 16'sd0);
        start_run();
        write_reg(CFG_LIMIT, LIMIT_TOP);
        write_reg(CFG_PAIRS, 7'd127);
        start_run();
        write_reg(CFG_LIMIT, '0);
        start_run();
        write_reg(CFG_LIMIT, '1);
        write_reg(CFG_PAIRS, 7'd1);
        start_run();
        write_reg(CFG_PAIRS, 7'd0);
        start_run();
    endtask

    task automatic test_random_runs();
        for (int r = 0; r < 6; r++) begin
            sender_no_gaps = (r % 3 == 1);
            write_reg(CFG_PAIRS, 7'($urandom_range(1, 70)));
            write_reg(CFG_LIMIT, (r % 2) ? DW'($urandom_range(1 << 20, 1 << 26))
                : DW'(64'd16777216));
            load_random($urandom_range(3, 10), $urandom_range(2, 8));
            start_run();
        end
        sender_no_gaps = 1'b0;
    endtask

    // Stall the receiver for a long stretch while requests keep coming,
    // then let the sender stand until every pair has drained.
    task automatic test_backpressure();
        write_reg(CFG_PAIRS, 7'd64);
        write_reg(CFG_LIMIT, DW'(64'd33554432));
        out_hold_cycles = 3000;
        send_req(REQ_START, 16'sd0, 16'sd0, 16'sd0);
        load_random(6, 6);
        send_req(REQ_START, 16'sd0, 16'sd0, 16'sd0);
        wait_idle();
    endtask

    // Receiver: random stalls, mostly short, plus a requested long hold-off.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                out_hold_cycles--;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: out_ch.ready <= 1'b0;
                    4: begin
                        out_ch.ready <= 1'b0;
                        out_hold_cycles = $urandom_range(10, 50);
                    end
                    default: out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Compare each transfer out with the oldest expected pair.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_pairs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pair src=%0d tgt=%0d", out_ch.source_index,
                        out_ch.target_index);
            end else begin
                t_match_pair e;
                e = pending_pairs.pop_front();
                if (out_ch.source_index !== e.src_idx || out_ch.target_index !== e.tgt_idx
                        || out_ch.match_found !== e.found || out_ch.distance_sq !== e.dist_sq
                        || out_ch.last_pair !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pair mismatch exp src=%0d tgt=%0d f=%0b d=%0d l=%0b %s",
                            e.src_idx, e.tgt_idx, e.found, e.dist_sq, e.last,
                            $sformatf("got src=%0d tgt=%0d f=%0b d=%0d l=%0b",
                            out_ch.source_index, out_ch.target_index,
                            out_ch.match_found, out_ch.distance_sq, out_ch.last_pair));
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_SRC;
        in_ch.feat_x = '0;
        in_ch.feat_y = '0;
        in_ch.feat_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_PAIRS;
        cfg_ch.data = '0;
        src_count = 0;
        tgt_count = 0;
        pairs_wanted = PAIRS_RESET;
        match_limit = LIMIT_RESET;
        settle_cycles = 20;
        mismatches = 0;
        out_hold_cycles = 0;
        sender_no_gaps = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_stores();
        test_extremes();
        test_random_runs();
        test_backpressure();
        test_random_runs();

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_pairs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== feature_nearest_match_topk.f =====
src/fnm_pkg.sv
src/fnm_if.sv
src/fnm_ram.sv
src/fnm_ctrl.sv
src/fnm_dp.sv
src/feature_nearest_match_topk.sv
tb/sv/feature_nearest_match_topk_test.sv
